// ===== design/smb_pkg.sv =====
`timescale 1ns / 1ps
// smb_pkg: types and constants for the smbus master sequencer
// used by every module of the block

package smb_pkg;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_STATUS  = 2'd1,
        ACT_TIMEOUT = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ADDRESS = 3'd1,
        PH_COMMAND = 3'd2,
        PH_REPSTRT = 3'd3,
        PH_QUICK   = 3'd4,
        PH_READ    = 3'd5,
        PH_WRITE   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        OC_OK         = 3'd0,
        OC_NO_DEVICE  = 3'd1,
        OC_IO_ERROR   = 3'd2,
        OC_INVALID    = 3'd3,
        OC_IDLE_EVENT = 3'd4
    } t_outcome;

    typedef enum logic [1:0] {
        ACK_LEAVE = 2'd0,
        ACK_SET   = 2'd1,
        ACK_CLEAR = 2'd2
    } t_ack;

    localparam logic [2:0] KIND_QUICK     = 3'd0;
    localparam logic [2:0] KIND_BYTE      = 3'd1;
    localparam logic [2:0] KIND_WORD      = 3'd3;
    localparam logic [2:0] KIND_BLOCK     = 3'd4;

    localparam logic [7:0] ST_DATA_READY  = 8'h40;
    localparam logic [7:0] ST_BUS_ERROR   = 8'h20;
    localparam logic [7:0] ST_NACK        = 8'h10;
    localparam logic [7:0] ST_MASTER      = 8'h02;
    localparam logic [7:0] ADDR_READ_BIT  = 8'h01;

    typedef struct packed {
        t_action    action;
        logic [6:0] slave_address;
        logic       read_request;
        logic [7:0] command_code;
        logic [2:0] transfer_kind;
        logic [7:0] block_length;
        logic [7:0] status_bits;
        logic [7:0] data_in;
    } t_req;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       issue_start;
        logic       issue_stop;
        t_ack       ack_control;
        logic       received_valid;
        logic [7:0] received_byte;
        logic       clear_flags;
        logic       finished;
        t_outcome   outcome;
        logic       reset_wanted;
    } t_rsp;

    typedef struct packed {
        logic fire;
        logic has_result;
    } t_core_ctl;

endpackage

// ===== design/smb_if.sv =====
`timescale 1ns / 1ps
// smb_req_if and smb_rsp_if: valid/ready channels of the sequencer
// no dependencies

interface smb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] slave_address;
    logic       read_request;
    logic [7:0] command_code;
    logic [2:0] transfer_kind;
    logic [7:0] block_length;
    logic [7:0] status_bits;
    logic [7:0] data_in;

    modport source (
        output valid, action, slave_address, read_request, command_code,
               transfer_kind, block_length, status_bits, data_in,
        input  ready
    );
    modport sink (
        input  valid, action, slave_address, read_request, command_code,
               transfer_kind, block_length, status_bits, data_in,
        output ready
    );
endinterface

interface smb_rsp_if;
    logic       valid;
    logic       ready;
    logic       send_valid;
    logic [7:0] send_byte;
    logic       issue_start;
    logic       issue_stop;
    logic [1:0] ack_control;
    logic       received_valid;
    logic [7:0] received_byte;
    logic       clear_flags;
    logic       finished;
    logic [2:0] outcome;
    logic       reset_wanted;

    modport source (
        output valid, send_valid, send_byte, issue_start, issue_stop, ack_control,
               received_valid, received_byte, clear_flags, finished, outcome,
               reset_wanted,
        input  ready
    );
    modport sink (
        input  valid, send_valid, send_byte, issue_start, issue_stop, ack_control,
               received_valid, received_byte, clear_flags, finished, outcome,
               reset_wanted,
        output ready
    );
endinterface

// ===== design/smb_core.sv =====
`timescale 1ns / 1ps
// smb_core: transaction state and the single-step sequencing logic
// depends on smb_pkg

module smb_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  smb_pkg::t_req     i_req,
    output logic              o_has_result,
    output smb_pkg::t_rsp     o_rsp
);
    import smb_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_addr, n_addr;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_rem, n_rem;
    logic       r_bwm, n_bwm;

    logic [7:0] w_len;
    logic       w_start_bad;
    logic       w_rd_req;
    logic       w_rd_cur;
    logic       w_st_any;
    logic       w_err;
    logic       w_nack;
    logic       w_rem_one;
    logic [7:0] w_rem_dec;
    t_ack       w_ack_next;

    always_comb begin
        case (i_req.transfer_kind)
            KIND_QUICK: w_len = 8'd0;
            KIND_WORD:  w_len = 8'd2;
            KIND_BLOCK: w_len = i_req.block_length;
            default:    w_len = 8'd1;
        endcase
    end

    assign w_rd_req    = i_req.read_request;
    assign w_rd_cur    = |(r_addr & ADDR_READ_BIT);
    assign w_start_bad = (r_phase != PH_IDLE) || (i_req.transfer_kind > KIND_BLOCK)
                         || (w_rd_req && (w_len == 8'd0));
    assign w_st_any    = |(i_req.status_bits & (ST_DATA_READY | ST_BUS_ERROR | ST_NACK));
    assign w_err       = (|(i_req.status_bits & ST_BUS_ERROR))
                         || !(|(i_req.status_bits & ST_MASTER));
    assign w_nack      = |(i_req.status_bits & ST_NACK);
    assign w_rem_one   = (r_rem == 8'd1);
    assign w_rem_dec   = r_rem - 8'd1;
    assign w_ack_next  = w_rem_one ? ACK_SET : ACK_CLEAR;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_cmd   = r_cmd;
        n_rem   = r_rem;
        n_bwm   = r_bwm;
        unique case (i_req.action)
            ACT_START: begin
                if (!w_start_bad) begin
                    n_addr  = {i_req.slave_address, w_rd_req};
                    n_cmd   = i_req.command_code;
                    n_rem   = w_len;
                    n_bwm   = (i_req.transfer_kind == KIND_BYTE) && !w_rd_req;
                    n_phase = (i_req.transfer_kind <= KIND_BYTE) ? PH_QUICK : PH_ADDRESS;
                end
            end
            ACT_STATUS: begin
                if (w_st_any && (r_phase != PH_IDLE)) begin
                    if (w_err || w_nack) begin
                        n_phase = PH_IDLE;
                    end else begin
                        unique case (r_phase)
                            PH_ADDRESS: n_phase = PH_COMMAND;
                            PH_COMMAND: n_phase = w_rd_cur ? PH_REPSTRT : PH_WRITE;
                            PH_REPSTRT, PH_QUICK: n_phase = w_rd_cur ? PH_READ : PH_WRITE;
                            PH_READ: begin
                                n_rem = w_rem_dec;
                                if (w_rem_one) begin
                                    n_phase = PH_IDLE;
                                end
                            end
                            PH_WRITE: begin
                                if (r_rem == 8'd0) begin
                                    n_phase = PH_IDLE;
                                end else begin
                                    n_rem = w_rem_dec;
                                end
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            ACT_TIMEOUT: n_phase = PH_IDLE;
            ACT_NONE: ;
            default: ;
        endcase
    end

    // result
    always_comb begin
        o_has_result = 1'b0;
        o_rsp        = '0;
        unique case (i_req.action)
            ACT_START: begin
                o_has_result = 1'b1;
                if (w_start_bad) begin
                    o_rsp.finished = 1'b1;
                    o_rsp.outcome  = OC_INVALID;
                end else begin
                    o_rsp.issue_start = 1'b1;
                end
            end
            ACT_STATUS: begin
                o_has_result = w_st_any;
                if (r_phase == PH_IDLE) begin
                    o_rsp.outcome = OC_IDLE_EVENT;
                end else if (w_err) begin
                    o_rsp.finished     = 1'b1;
                    o_rsp.outcome      = OC_IO_ERROR;
                    o_rsp.reset_wanted = 1'b1;
                end else if (w_nack) begin
                    o_rsp.issue_stop  = 1'b1;
                    o_rsp.clear_flags = 1'b1;
                    o_rsp.finished    = 1'b1;
                    o_rsp.outcome     = OC_NO_DEVICE;
                end else begin
                    unique case (r_phase)
                        PH_ADDRESS: begin
                            o_rsp.send_valid = 1'b1;
                            o_rsp.send_byte  = r_addr & ~ADDR_READ_BIT;
                        end
                        PH_COMMAND: begin
                            o_rsp.send_valid = 1'b1;
                            o_rsp.send_byte  = r_cmd;
                        end
                        PH_REPSTRT, PH_QUICK: begin
                            o_rsp.issue_start = (r_phase == PH_REPSTRT);
                            if (w_rd_cur) begin
                                o_rsp.ack_control = w_ack_next;
                            end
                            o_rsp.send_valid = 1'b1;
                            o_rsp.send_byte  = r_addr;
                        end
                        PH_READ: begin
                            o_rsp.ack_control    = w_ack_next;
                            o_rsp.received_valid = 1'b1;
                            o_rsp.received_byte  = i_req.data_in;
                            if (w_rem_one) begin
                                o_rsp.issue_stop = 1'b1;
                                o_rsp.finished   = 1'b1;
                            end
                        end
                        PH_WRITE: begin
                            if (r_rem == 8'd0) begin
                                o_rsp.issue_stop = 1'b1;
                                o_rsp.finished   = 1'b1;
                            end else begin
                                o_rsp.send_valid = 1'b1;
                                o_rsp.send_byte  = r_bwm ? r_cmd : i_req.data_in;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ACT_TIMEOUT: begin
                o_has_result = 1'b1;
                if (r_phase == PH_IDLE) begin
                    o_rsp.outcome = OC_IDLE_EVENT;
                end else begin
                    o_rsp.finished     = 1'b1;
                    o_rsp.outcome      = OC_IO_ERROR;
                    o_rsp.reset_wanted = 1'b1;
                end
            end
            ACT_NONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= '0;
            r_cmd   <= '0;
            r_rem   <= '0;
            r_bwm   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_cmd   <= n_cmd;
            r_rem   <= n_rem;
            r_bwm   <= n_bwm;
        end
    end

`ifndef SYNTHESIS
    a_timeout_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.action == ACT_TIMEOUT) |=> (r_phase == PH_IDLE))
        else $error("timeout did not return the sequencer to idle");

    a_quiet_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.action == ACT_STATUS && !w_st_any) |=> $stable(r_phase))
        else $error("quiet status changed the phase");

    a_ok_has_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_has_result && o_rsp.finished && o_rsp.outcome == OC_OK) |-> o_rsp.issue_stop)
        else $error("transaction finished without stop");

    a_start_leaves_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_rsp.issue_start && i_req.action == ACT_START)
        |=> (r_phase == PH_QUICK || r_phase == PH_ADDRESS))
        else $error("accepted start did not enter a busy phase");
`endif

endmodule

// ===== design/smb_out_stage.sv =====
`timescale 1ns / 1ps
// smb_out_stage: result register in front of the response channel
// depends on smb_pkg

module smb_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  smb_pkg::t_core_ctl i_ctl,
    input  smb_pkg::t_rsp     i_rsp,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output smb_pkg::t_rsp     o_rsp
);
    import smb_pkg::*;

    logic r_valid;
    t_rsp r_rsp;
    logic w_load;

    assign o_free  = !r_valid || i_ready;
    assign w_load  = i_ctl.fire && i_ctl.has_result;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

// ===== design/smbus_master_sequencer.sv =====
`timescale 1ns / 1ps
// smbus_master_sequencer: top level of the smbus master transaction sequencer
// depends on smb_pkg, smb_if, smb_core, smb_out_stage
//
// i_req carries one request per handshake: a start (address, direction,
// command, kind, length), a controller status event or a timeout.
// o_rsp carries at most one response per request: the byte to send, the
// start/stop/ack controls, a received byte and the transaction outcome.
// a quiet status event and the unused action code produce no response.
// both channels use valid/ready; a transfer happens when both are high.
// a request is captured in an input register, stepped through the
// sequencer and the response is loaded into the result register.
// throughput is one request per cycle while o_rsp is not stalled; the
// sequencer state is the only loop.
// when o_rsp is stalled the result register holds, the input register
// keeps its request and i_req.ready drops only once both are full; a
// request that produces no response still moves on while stalled.
// synchronous reset returns the sequencer to idle and empties both
// registers; no clearing pass is needed.

module smbus_master_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    smb_req_if.sink     i_req,
    smb_rsp_if.source   o_rsp
);
    import smb_pkg::*;

    logic      r_in_valid;
    t_req      r_in;
    t_core_ctl w_ctl;
    t_rsp      w_core_rsp;
    t_rsp      w_out_rsp;
    logic      w_has_result;
    logic      w_out_free;
    logic      w_in_ready;

    assign w_ctl.has_result = w_has_result;
    assign w_ctl.fire       = r_in_valid && (w_out_free || !w_has_result);
    assign w_in_ready       = !r_in_valid || w_ctl.fire;
    assign i_req.ready      = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_req.valid) begin
            r_in.action        <= t_action'(i_req.action);
            r_in.slave_address <= i_req.slave_address;
            r_in.read_request  <= i_req.read_request;
            r_in.command_code  <= i_req.command_code;
            r_in.transfer_kind <= i_req.transfer_kind;
            r_in.block_length  <= i_req.block_length;
            r_in.status_bits   <= i_req.status_bits;
            r_in.data_in       <= i_req.data_in;
        end
    end

    smb_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_ctl.fire),
        .i_req        (r_in),
        .o_has_result (w_has_result),
        .o_rsp        (w_core_rsp)
    );

    smb_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rsp   (w_core_rsp),
        .i_ready (o_rsp.ready),
        .o_free  (w_out_free),
        .o_valid (o_rsp.valid),
        .o_rsp   (w_out_rsp)
    );

    assign o_rsp.send_valid     = w_out_rsp.send_valid;
    assign o_rsp.send_byte      = w_out_rsp.send_byte;
    assign o_rsp.issue_start    = w_out_rsp.issue_start;
    assign o_rsp.issue_stop     = w_out_rsp.issue_stop;
    assign o_rsp.ack_control    = w_out_rsp.ack_control;
    assign o_rsp.received_valid = w_out_rsp.received_valid;
    assign o_rsp.received_byte  = w_out_rsp.received_byte;
    assign o_rsp.clear_flags    = w_out_rsp.clear_flags;
    assign o_rsp.finished       = w_out_rsp.finished;
    assign o_rsp.outcome        = w_out_rsp.outcome;
    assign o_rsp.reset_wanted   = w_out_rsp.reset_wanted;

endmodule
